// ----- rtl/deq_pkg.sv -----
`timescale 1ns / 1ps

package deq_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  // Status reported with every result item
  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2
  } err_e;

  // Request sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  // Fixed widths of the stream fields
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned InW    = 32;
  localparam int unsigned OutW   = 80;

  // Fields of one result item, highest bit first when packed
  typedef struct packed {
    logic [2:0]        pad;
    err_e              error_code;
    logic [CountW-1:0] element_count;
    logic [WordW-1:0]  back_value;
    logic [WordW-1:0]  front_value;
  } result_t;

endpackage

// ----- rtl/deq_ram.sv -----
`timescale 1ns / 1ps

// Word store: one write port, two read ports, registered read data
module deq_ram #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AddrW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0]      raddr_a_i,
  input  logic [AddrW-1:0]      raddr_b_i,
  output logic [DATA_WIDTH-1:0] rdata_a_o,
  output logic [DATA_WIDTH-1:0] rdata_b_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read two entries
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                              tuser
// s_axis    in         data_value[31:0]                                req_type[1:0]
// m_axis    out        front_value, back_value, element_count,         -
//                      error_code, 3 zero bits
//
// An item is accepted in the idle state; pointers and the push write update at that edge.
// The next cycle reads the front and back entries; the load state after it loads the result
// register, a step set by the registered read of the word store.
// A waiting result does not block the next item; only the load step waits for m_axis.
// Reset clears pointers and count; the store is not cleared and needs no clearing pass.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,  // data_value[31:0]
  input  logic [1:0]      s_axis_tuser,  // req_type[1:0]
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata   // front[31:0] back[63:32] count[74:64] err[76:75]
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  function automatic logic [PtrW-1:0] ring_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PtrW-1:0] ring_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? LastPtr : p - 1'b1;
  endfunction

  state_e          state_q, state_d;
  logic [PtrW-1:0] front_q, front_d;
  logic [PtrW-1:0] back_q, back_d;
  logic [CntW-1:0] count_q, count_d;
  err_e            err_q, err_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic                  s_accept;
  logic                  m_accept;
  req_e                  req;
  logic                  we;
  logic [PtrW-1:0]       waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] front_word;
  logic [DATA_WIDTH-1:0] back_word;

  assign req      = req_e'(s_axis_tuser);
  assign wdata    = DATA_WIDTH'(s_axis_tdata);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  // Next state, pointer update and result load
  always_comb begin
    state_d       = state_q;
    front_d       = front_q;
    back_d        = back_q;
    count_d       = count_q;
    err_d         = err_q;
    out_valid_d   = out_valid_q && !m_accept;
    out_d         = out_q;
    we            = 1'b0;
    waddr         = back_q;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          err_d   = ERR_OK;
          state_d = ST_READ;
          case (req)
            REQ_PUSH_FRONT: begin
              if (count_q == FullCnt) begin
                err_d = ERR_OVERFLOW;
              end else begin
                we      = 1'b1;
                waddr   = ring_dec(front_q);
                front_d = ring_dec(front_q);
                count_d = count_q + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              if (count_q == FullCnt) begin
                err_d = ERR_OVERFLOW;
              end else begin
                we      = 1'b1;
                waddr   = back_q;
                back_d  = ring_inc(back_q);
                count_d = count_q + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (count_q == '0) begin
                err_d = ERR_UNDERFLOW;
              end else begin
                front_d = ring_inc(front_q);
                count_d = count_q - 1'b1;
              end
            end
            default: begin
              if (count_q == '0) begin
                err_d = ERR_UNDERFLOW;
              end else begin
                back_d  = ring_dec(back_q);
                count_d = count_q - 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Hold while the previous result still waits
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d         = 1'b1;
          out_d.pad           = '0;
          out_d.error_code    = err_q;
          out_d.element_count = CountW'(count_q);
          out_d.front_value   = (count_q == '0) ? '0 : WordW'(front_word);
          out_d.back_value    = (count_q == '0) ? '0 : WordW'(back_word);
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    out_q <= out_d;
  end

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AddrW      (PtrW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (front_q),
    .raddr_b_i (ring_dec(back_q)),
    .rdata_a_o (front_word),
    .rdata_b_o (back_word)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Fill count stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("fill count exceeds depth");

  // Pointer distance matches the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((back_q >= front_q) ? (32'(back_q) - 32'(front_q))
                         : (32'(back_q) + DEPTH - 32'(front_q)))
    == ((count_q == FullCnt) ? 32'd0 : 32'(count_q)))
    else $error("pointers disagree with fill count");

  // A push into a ring with room adds one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) && count_q != FullCnt
    |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the queue");

  // Underflow is only reported for an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.error_code == ERR_UNDERFLOW |-> out_q.element_count == '0)
    else $error("underflow reported with words stored");

endmodule
